FILE: hw/rtl/glc_pkg.sv
// Shared types and constants of the grid cell locator.
// Used by the stream interfaces, the top level and the port checker.
package glc_pkg;

	// Fixed field widths
	localparam int CELL_W  = 10;
	localparam int ADDR_W  = 11;
	localparam int LEVEL_W = 4;

	// Kinds of input beat
	localparam logic KIND_LOAD   = 1'b0;
	localparam logic KIND_LOCATE = 1'b1;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_STRETCHED   = 2'd0,
		CFG_TABLE_LEVEL = 2'd1,
		CFG_DOMAIN_MIN  = 2'd2,
		CFG_DOMAIN_MAX  = 2'd3
	} cfg_idx_t;

endpackage

FILE: hw/rtl/glc_stream_if.sv
// Valid/ready stream interfaces for the locator's input and result channels.
// Depends on glc_pkg for the fixed field widths.
interface glc_in_if #(
	parameter int COORD_BITS = 32
);
	import glc_pkg::*;

	logic                         valid;
	logic                         ready;
	logic                         kind;
	logic [ADDR_W-1:0]            table_addr;
	logic signed [COORD_BITS-1:0] point_value;
	logic signed [COORD_BITS-1:0] query_coord;
	logic [LEVEL_W-1:0]           query_level;

	modport source (
		output valid, kind, table_addr, point_value, query_coord, query_level,
		input  ready
	);
	modport sink (
		input  valid, kind, table_addr, point_value, query_coord, query_level,
		output ready
	);
endinterface

interface glc_out_if #(
	parameter int FRAC_BITS = 16
);
	import glc_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CELL_W-1:0]    cell_index;
	logic [FRAC_BITS-1:0] fraction;
	logic                 out_of_range;

	modport source (
		output valid, cell_index, fraction, out_of_range,
		input  ready
	);
	modport sink (
		input  valid, cell_index, fraction, out_of_range,
		output ready
	);
endinterface

FILE: hw/rtl/grid_cell_locate_top.sv
// Grid cell locator: breakpoint table, bisection/scaling sequencer, serial divider.
// Depends on glc_pkg and the stream interfaces in glc_stream_if.sv.
//
// Usage:
//   in_ch carries load beats (kind 0) that write one breakpoint into the table,
//   and locate beats (kind 1) that return one result beat on out_ch with the
//   cell start index, the Q0.FRAC_BITS fraction and an out-of-range flag.
//   The config port (cfg_we, cfg_index, cfg_data) sets the mode, the table
//   level and the uniform domain bounds; write it only while the block is idle.
// Sequencing and throughput:
//   A load beat leaves the block idle and ready. A locate beat keeps in_ch.ready
//   low while one shared subtract/compare unit walks through the work: in
//   stretched mode bisection steps (one table read and one compare per step),
//   then the cell bound reads, range checks and divider; in uniform mode the
//   domain and range checks and the divider. A coordinate outside its cell or
//   an empty domain skips the divider and ends sooner. in_ch.ready rises as the
//   result is loaded. One quotient bit per cycle on the same unit; unless out_ch
//   stalls, the divider and the bisection set the rate.
// Reset and stall:
//   arst_n clears the sequencer, the result slot and the config registers
//   (domain_max to 65536); the table holds garbage until written. A finished
//   result waits in the output register; the next beat is accepted meanwhile,
//   and a new result waits in its final state until the slot is free.
module grid_cell_locate_top #(
	parameter int MAX_LEVEL  = 10,
	parameter int COORD_BITS = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	glc_in_if.sink                in_ch,
	glc_out_if.source             out_ch,
	input  logic                  cfg_we,
	input  glc_pkg::cfg_idx_t     cfg_index,
	input  logic [COORD_BITS-1:0] cfg_data
);
	import glc_pkg::*;

	localparam int DEPTH = (1 << MAX_LEVEL) + 1;
	localparam int AW    = MAX_LEVEL + 1;
	localparam int LVW   = $clog2(MAX_LEVEL + 1);
	localparam int QW    = MAX_LEVEL + FRAC_BITS + 1;
	localparam int CW    = $clog2(MAX_LEVEL + FRAC_BITS + 1);
	localparam int CB    = COORD_BITS;
	localparam logic [CB-1:0]        SIGN_BIT = {1'b1, {(CB-1){1'b0}}};
	localparam logic [FRAC_BITS-1:0] FRAC_MAX = {FRAC_BITS{1'b1}};

	typedef enum logic [12:0] {
		S_IDLE = 13'b0000000000001,
		S_BIS  = 13'b0000000000010,
		S_CMP  = 13'b0000000000100,
		S_GETS = 13'b0000000001000,
		S_GETE = 13'b0000000010000,
		S_DOM  = 13'b0000000100000,
		S_LO   = 13'b0000001000000,
		S_HI   = 13'b0000010000000,
		S_DEN  = 13'b0000100000000,
		S_DIV0 = 13'b0001000000000,
		S_DIV  = 13'b0010000000000,
		S_FIN  = 13'b0100000000000,
		S_OUT  = 13'b1000000000000
	} state_t;

	state_t state_q, state_d;

	// Configuration registers
	logic               mode_q;
	logic [LEVEL_W-1:0] tlev_q;
	logic [CB-1:0]      dmin_q, dmax_q;

	// Sequencer working registers
	logic [CB-1:0]        c_q, ts_q, te_q, r_q, den_q;
	logic [AW-1:0]        s_q, e_q, mid_q;
	logic [LVW-1:0]       ql_q, diff_q;
	logic [QW-1:0]        q_q;
	logic [CW-1:0]        cnt_q;
	logic [CELL_W-1:0]    res_cell_q;
	logic [FRAC_BITS-1:0] res_frac_q;
	logic                 res_oor_q;

	// Result slot
	logic                 out_valid_q;
	logic [CELL_W-1:0]    out_cell_q;
	logic [FRAC_BITS-1:0] out_frac_q;
	logic                 out_oor_q;

	// Breakpoint table
	logic [CB-1:0] mem [DEPTH];
	logic [CB-1:0] rd_data_q;
	logic [AW-1:0] rd_addr;

	logic          in_fire, out_load;
	logic [31:0]   addr_ext;
	logic          addr_ok;
	logic [LVW-1:0] ql_sat, tl_sat, diff_lv;

	// Bisection helpers
	logic [AW:0]   mid_sum;
	logic [AW-1:0] mid, span, width, s_cell, last_u, last_eff, idx;
	logic          bis_more, over;

	// Shared subtract/compare unit
	logic [CB:0]   alu_a, alu_b;
	logic [CB+1:0] alu_d;
	logic          alu_lt, alu_zero;
	logic [CB:0]   r_shift;

	assign in_fire  = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == S_IDLE);
	assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ch.ready);

	assign addr_ext = 32'(in_ch.table_addr);
	assign addr_ok  = addr_ext < 32'(DEPTH);

	// Saturate levels and form the level difference
	always_comb begin
		ql_sat  = (32'(in_ch.query_level) > 32'(MAX_LEVEL)) ? LVW'(MAX_LEVEL)
			: LVW'(in_ch.query_level);
		tl_sat  = (32'(tlev_q) > 32'(MAX_LEVEL)) ? LVW'(MAX_LEVEL) : LVW'(tlev_q);
		diff_lv = (tl_sat > ql_sat) ? LVW'(tl_sat - ql_sat) : '0;
	end

	// Bisection interval and cell arithmetic
	always_comb begin
		mid_sum  = {1'b0, s_q} + {1'b0, e_q};
		mid      = mid_sum[AW:1];
		span     = AW'(1) << diff_q;
		width    = e_q - s_q;
		bis_more = width > span;
		s_cell   = s_q >> diff_q;
		last_u   = (AW'(1) << ql_q) - AW'(1);
		last_eff = mode_q ? '0 : last_u;
		idx      = q_q[QW-1:FRAC_BITS];
		over     = idx > last_eff;
	end

	// Table read address per state
	always_comb begin
		case (state_q)
			S_BIS:   rd_addr = bis_more ? mid : s_q;
			S_GETS:  rd_addr = e_q;
			default: rd_addr = s_q;
		endcase
	end

	// Operand select for the shared unit
	always_comb begin
		r_shift = {r_q, 1'b0};
		case (state_q)
			S_CMP: begin
				alu_a = {1'b0, rd_data_q ^ SIGN_BIT};
				alu_b = {1'b0, c_q};
			end
			S_LO: begin
				alu_a = {1'b0, c_q};
				alu_b = {1'b0, ts_q};
			end
			S_HI: begin
				alu_a = {1'b0, te_q};
				alu_b = {1'b0, c_q};
			end
			S_DIV0: begin
				alu_a = {1'b0, r_q};
				alu_b = {1'b0, den_q};
			end
			S_DIV: begin
				alu_a = r_shift;
				alu_b = {1'b0, den_q};
			end
			default: begin
				alu_a = {1'b0, te_q};
				alu_b = {1'b0, ts_q};
			end
		endcase
		alu_d    = {1'b0, alu_a} - {1'b0, alu_b};
		alu_lt   = alu_d[CB+1];
		alu_zero = (alu_d == '0);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_fire && in_ch.kind == KIND_LOCATE)
					state_d = mode_q ? S_BIS : S_DOM;
			end
			S_BIS:  state_d = bis_more ? S_CMP : S_GETS;
			S_CMP:  state_d = S_BIS;
			S_GETS: state_d = S_GETE;
			S_GETE: state_d = S_LO;
			S_DOM:  state_d = (alu_lt || alu_zero) ? S_OUT : S_LO;
			S_LO:   state_d = alu_lt ? S_OUT : S_HI;
			S_HI:   state_d = alu_lt ? S_OUT : S_DEN;
			S_DEN:  state_d = alu_zero ? S_OUT : S_DIV0;
			S_DIV0: state_d = S_DIV;
			S_DIV:  state_d = (cnt_q == CW'(1)) ? S_FIN : S_DIV;
			S_FIN:  state_d = S_OUT;
			S_OUT:  state_d = out_load ? S_IDLE : S_OUT;
			default: state_d = S_IDLE;
		endcase
	end

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			tlev_q <= '0;
			dmin_q <= '0;
			dmax_q <= CB'(65536);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_STRETCHED:   mode_q <= cfg_data[0];
				CFG_TABLE_LEVEL: tlev_q <= cfg_data[LEVEL_W-1:0];
				CFG_DOMAIN_MIN:  dmin_q <= cfg_data;
				CFG_DOMAIN_MAX:  dmax_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Table write on an in-range load beat, registered read every cycle
	always_ff @(posedge clk) begin
		if (in_fire && in_ch.kind == KIND_LOAD && addr_ok)
			mem[addr_ext[AW-1:0]] <= in_ch.point_value;
		rd_data_q <= mem[rd_addr];
	end

	// Datapath registers advanced by the sequencer
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				c_q    <= in_ch.query_coord ^ SIGN_BIT;
				ql_q   <= ql_sat;
				diff_q <= diff_lv;
				s_q    <= '0;
				e_q    <= AW'(1) << tl_sat;
				ts_q   <= dmin_q ^ SIGN_BIT;
				te_q   <= dmax_q ^ SIGN_BIT;
			end
			S_BIS: begin
				mid_q <= mid;
			end
			S_CMP: begin
				if (alu_lt)
					s_q <= mid_q;
				else
					e_q <= mid_q;
			end
			S_GETS: begin
				ts_q <= rd_data_q ^ SIGN_BIT;
			end
			S_GETE: begin
				te_q <= rd_data_q ^ SIGN_BIT;
			end
			S_DOM: begin
				res_cell_q <= '0;
				res_frac_q <= '0;
				res_oor_q  <= 1'b1;
			end
			S_LO: begin
				// below the start: fraction zero
				r_q        <= alu_d[CB-1:0];
				res_cell_q <= mode_q ? CELL_W'(s_cell) : '0;
				res_frac_q <= '0;
				res_oor_q  <= 1'b1;
			end
			S_HI: begin
				// above the end: fraction at its maximum
				res_cell_q <= mode_q ? CELL_W'(s_cell) : CELL_W'(last_u);
				res_frac_q <= FRAC_MAX;
				res_oor_q  <= 1'b1;
			end
			S_DEN: begin
				// equal bounds with the coordinate on them
				den_q      <= alu_d[CB-1:0];
				res_cell_q <= mode_q ? CELL_W'(s_cell) : '0;
				res_frac_q <= '0;
				res_oor_q  <= 1'b0;
			end
			S_DIV0: begin
				q_q   <= QW'(!alu_lt);
				if (!alu_lt)
					r_q <= alu_d[CB-1:0];
				cnt_q <= mode_q ? CW'(FRAC_BITS) : CW'(ql_q) + CW'(FRAC_BITS);
			end
			S_DIV: begin
				// one restoring step per cycle
				q_q   <= {q_q[QW-2:0], !alu_lt};
				r_q   <= alu_lt ? r_shift[CB-1:0] : alu_d[CB-1:0];
				cnt_q <= cnt_q - CW'(1);
			end
			S_FIN: begin
				res_frac_q <= over ? FRAC_MAX : q_q[FRAC_BITS-1:0];
				res_cell_q <= mode_q ? CELL_W'(s_cell) : (over ? CELL_W'(last_u) : CELL_W'(idx));
				res_oor_q  <= 1'b0;
			end
			default: ;
		endcase
	end

	// Result slot: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_cell_q <= res_cell_q;
			out_frac_q <= res_frac_q;
			out_oor_q  <= res_oor_q;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.cell_index   = out_cell_q;
	assign out_ch.fraction     = out_frac_q;
	assign out_ch.out_of_range = out_oor_q;

endmodule

FILE: hw/rtl/glc_check.sv
// Port-level checker for the grid cell locator, bound to its top level.
// Depends on glc_pkg and grid_cell_locate_top.
module glc_check #(
	parameter int FRAC_BITS = 16
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       in_kind,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [glc_pkg::CELL_W-1:0] out_cell,
	input logic [FRAC_BITS-1:0]       out_frac,
	input logic                       out_oor
);
	import glc_pkg::*;

	// Result beat holds while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_cell) && $stable(out_frac)
			&& $stable(out_oor))
		else $error("stalled result payload changed");

	// A locate beat makes the block busy
	a_locate_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_kind == KIND_LOCATE |=> !in_ready)
		else $error("input still ready after a locate beat");

	// A new result appears only as the sequencer ends its work
	a_result_end: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready && !$past(in_ready))
		else $error("result appeared without a finished locate");

endmodule

bind grid_cell_locate_top glc_check #(
	.FRAC_BITS(FRAC_BITS)
) u_glc_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.in_kind   (in_ch.kind),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_cell  (out_ch.cell_index),
	.out_frac  (out_ch.fraction),
	.out_oor   (out_ch.out_of_range)
);
